/* src/bbw_pkg.sv */
// ----------------------------------------------------------------------------
// bbw_pkg
// shared types and constants for the rgb box blur window block
// ----------------------------------------------------------------------------
package bbw_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int COORD_W    = 10;
    localparam int RAD_W      = 3;
    localparam int CFG_W      = 11;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int MAX_HEIGHT = 1024;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_NONE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_CALC = 2'd1,
        B_DIV  = 2'd2,
        B_EMIT = 2'd3
    } back_state_t;

    typedef struct packed {
        logic               first_row;
        logic               sub_old;
        logic               col_start;
        logic               emit;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
    } front_ctrl_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_status_t;

endpackage

/* src/box_blur_rgb_window.sv */
// ----------------------------------------------------------------------------
// box_blur_rgb_window
// streaming (2r+1) x (2r+1) mean filter over 24-bit raster pixels
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one request per pixel; for a nonzero radius a
// result request leaves for each pixel whose full window lies inside the
// frame, carrying the window centre and the three truncated byte means.
// Every pixel passes through the back-end steps in order (fetch from the
// line store and column sum memories, sum update, reciprocal multiply,
// result load), and the back end takes no new pixel until it is through
// with the last; a four-entry queue lets the input keep flowing while the
// back end works or a result waits. Any write to radius, image_width or
// image_height restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module box_blur_rgb_window #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bbw_pkg::ADDR_W-1:0]    paddr,
    input  logic [bbw_pkg::DATA_W-1:0]    pwdata,
    output logic [bbw_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bbw_pkg::PIX_W-1:0]     first_byte,
    input  logic [bbw_pkg::PIX_W-1:0]     second_byte,
    input  logic [bbw_pkg::PIX_W-1:0]     third_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bbw_pkg::COORD_W-1:0]   center_row,
    output logic [bbw_pkg::COORD_W-1:0]   center_col,
    output logic [bbw_pkg::PIX_W-1:0]     mean_first,
    output logic [bbw_pkg::PIX_W-1:0]     mean_second,
    output logic [bbw_pkg::PIX_W-1:0]     mean_third
);

    import bbw_pkg::*;

    localparam int LINES   = 2 * MAX_RADIUS + 1;
    localparam int RW      = $clog2(MAX_RADIUS + 1);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int LAW     = $clog2(LINES * MAX_WIDTH);
    localparam int WEW     = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int CTRL_W  = $bits(front_ctrl_t);
    localparam int Q_W     = CTRL_W + RGB_W + 2 * LAW + CW;
    localparam int Q_DEPTH = 4;

    logic [RAD_W-1:0]  radius_reg;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    cfg_reg_t          cfg_idx;
    logic              cfg_wr;
    logic              cfg_hit;

    logic [RW-1:0]     r_eff;
    logic [WEW-1:0]    w_eff;
    logic [CFG_W-1:0]  h_eff;

    logic              push;
    logic              q_full;
    logic              q_empty;
    front_ctrl_t       f_ctrl;
    logic [LAW-1:0]    f_cur_addr;
    logic [LAW-1:0]    f_old_addr;
    logic [CW-1:0]     f_col;
    logic [Q_W-1:0]    q_din;
    logic [Q_W-1:0]    q_dout;
    front_ctrl_t       q_ctrl;
    logic [RGB_W-1:0]  q_pixel;
    logic [LAW-1:0]    q_cur_addr;
    logic [LAW-1:0]    q_old_addr;
    logic [CW-1:0]     q_col;
    back_status_t      bstat;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (cfg_idx == REG_RADIUS || cfg_idx == REG_WIDTH
                                || cfg_idx == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(1);
            width_reg  <= CFG_W'(1024);
            height_reg <= CFG_W'(1024);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:    radius_reg <= radius_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_RADIUS: prdata = DATA_W'(radius_reg);
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // effective radius and frame size
    always_comb
    begin
        r_eff = (int'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        if (width_reg == '0)
        begin
            w_eff = WEW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WEW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WEW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = CFG_W'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    bbw_front #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_hit),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .r_eff    (r_eff),
        .w_eff    (w_eff),
        .h_eff    (h_eff),
        .q_full   (q_full),
        .push     (push),
        .ctrl     (f_ctrl),
        .cur_addr (f_cur_addr),
        .old_addr (f_old_addr),
        .col      (f_col)
    );

    assign q_din = {f_ctrl, third_byte, second_byte, first_byte, f_cur_addr, f_old_addr, f_col};

    bbw_queue #(.WIDTH(Q_W), .DEPTH(Q_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .pop   (bstat.pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {q_ctrl, q_pixel, q_cur_addr, q_old_addr, q_col} = q_dout;

    bbw_back #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_ctrl      (q_ctrl),
        .q_pixel     (q_pixel),
        .q_cur_addr  (q_cur_addr),
        .q_old_addr  (q_old_addr),
        .q_col       (q_col),
        .r_eff       (r_eff),
        .status      (bstat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .center_row  (center_row),
        .center_col  (center_col),
        .mean_first  (mean_first),
        .mean_second (mean_second),
        .mean_third  (mean_third)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.pop |-> !q_empty)
        else $error("back end popped an empty queue");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(bstat.busy))
        else $error("result appeared without back-end work");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_full && !bstat.pop |=> !q_empty)
        else $error("queue lost entries");

endmodule

/* src/bbw_ram.sv */
// ----------------------------------------------------------------------------
// bbw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bbw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/bbw_queue.sv */
// ----------------------------------------------------------------------------
// bbw_queue
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module bbw_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int PTRW = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTRW-1:0]  wptr_reg, wptr_next;
    logic [PTRW-1:0]  rptr_reg, rptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTRW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTRW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

    assign dout  = slot_reg[rptr_reg];
    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

/* src/bbw_front.sv */
// ----------------------------------------------------------------------------
// bbw_front
// raster position tracking and per-pixel classification
// ----------------------------------------------------------------------------
module bbw_front #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024,
    localparam int LINES = 2 * MAX_RADIUS + 1,
    localparam int RW    = $clog2(MAX_RADIUS + 1),
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int LW    = $clog2(LINES),
    localparam int LAW   = $clog2(LINES * MAX_WIDTH),
    localparam int WEW   = (CW + 1 > bbw_pkg::CFG_W) ? CW + 1 : bbw_pkg::CFG_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        restart,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [RW-1:0]               r_eff,
    input  logic [WEW-1:0]              w_eff,
    input  logic [bbw_pkg::CFG_W-1:0]   h_eff,
    input  logic                        q_full,
    output logic                        push,
    output bbw_pkg::front_ctrl_t        ctrl,
    output logic [LAW-1:0]              cur_addr,
    output logic [LAW-1:0]              old_addr,
    output logic [CW-1:0]               col
);

    import bbw_pkg::*;

    logic [COORD_W-1:0] row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [LW-1:0]      line_reg, line_next;
    logic [RW:0]        side;
    logic [RW:0]        two_r;
    logic [LW-1:0]      old_line;

    assign side  = {r_eff, 1'b1};
    assign two_r = {r_eff, 1'b0};

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign old_line = (line_reg >= LW'(side)) ? line_reg - LW'(side)
                                              : line_reg + LW'(LINES) - LW'(side);

    assign cur_addr = LAW'(line_reg) * LAW'(MAX_WIDTH) + LAW'(col_reg);
    assign old_addr = LAW'(old_line) * LAW'(MAX_WIDTH) + LAW'(col_reg);
    assign col      = col_reg;

    always_comb
    begin
        ctrl.first_row  = (row_reg == '0);
        ctrl.sub_old    = (int'(row_reg) >= int'(side));
        ctrl.col_start  = (col_reg == '0);
        ctrl.emit       = (r_eff != '0) && (int'(r_eff) < int'(w_eff))
                          && (int'(r_eff) < int'(h_eff))
                          && (int'(row_reg) >= int'(two_r))
                          && (int'(col_reg) >= int'(two_r));
        ctrl.center_row = row_reg - COORD_W'(r_eff);
        ctrl.center_col = COORD_W'(col_reg - CW'(r_eff));
    end

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        line_next = line_reg;
        if (restart)
        begin
            row_next  = '0;
            col_next  = '0;
            line_next = '0;
        end
        else if (push)
        begin
            if (int'(col_reg) + 1 >= int'(w_eff))
            begin
                col_next = '0;
                if (int'(row_reg) + 1 >= int'(h_eff))
                begin
                    row_next  = '0;
                    line_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    line_next = (line_reg == LW'(LINES - 1)) ? '0 : line_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

/* src/bbw_back.sv */
// ----------------------------------------------------------------------------
// bbw_back
// column sums, horizontal window, mean scaling and result register
// ----------------------------------------------------------------------------
module bbw_back #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024,
    localparam int LINES = 2 * MAX_RADIUS + 1,
    localparam int RW    = $clog2(MAX_RADIUS + 1),
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int LW    = $clog2(LINES),
    localparam int LAW   = $clog2(LINES * MAX_WIDTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  bbw_pkg::front_ctrl_t          q_ctrl,
    input  logic [bbw_pkg::RGB_W-1:0]     q_pixel,
    input  logic [LAW-1:0]                q_cur_addr,
    input  logic [LAW-1:0]                q_old_addr,
    input  logic [CW-1:0]                 q_col,
    input  logic [RW-1:0]                 r_eff,
    output bbw_pkg::back_status_t         status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bbw_pkg::COORD_W-1:0]   center_row,
    output logic [bbw_pkg::COORD_W-1:0]   center_col,
    output logic [bbw_pkg::PIX_W-1:0]     mean_first,
    output logic [bbw_pkg::PIX_W-1:0]     mean_second,
    output logic [bbw_pkg::PIX_W-1:0]     mean_third
);

    import bbw_pkg::*;

    localparam int CSW = $clog2(LINES * 255 + 1);
    localparam int SW  = $clog2(LINES * LINES * 255 + 1);
    localparam int S   = SW + 2 * LW;
    localparam int PW  = SW + S;

    back_state_t        state_reg, state_next;
    front_ctrl_t        ctrl_reg;
    logic [RGB_W-1:0]   pix_reg;
    logic [LAW-1:0]     cur_addr_reg;
    logic [CW-1:0]      col_reg;

    logic [CSW-1:0]     win_reg [LINES][3];
    logic [CSW-1:0]     win_next [LINES][3];
    logic [SW-1:0]      sum_reg [3];
    logic [SW-1:0]      sum_next [3];
    logic [PW-1:0]      prod_reg [3];
    logic [CSW-1:0]     col_sum [3];
    logic [3*CSW-1:0]   cs_wdata;
    logic [3*CSW-1:0]   cs_rdata;
    logic [RGB_W-1:0]   ls_rdata;
    logic [S-1:0]       recip_tab [MAX_RADIUS+1];
    logic [LW-1:0]      drop_idx;

    logic               pop;
    logic               calc_en;
    logic               div_en;
    logic               load_out;

    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] center_row_reg, center_col_reg;
    logic [PIX_W-1:0]   mean_reg [3];

    // rounded-up reciprocal of the window area, giving the exact truncated mean for every window sum
    assign recip_tab[0] = '0;
    for (genvar i = 1; i <= MAX_RADIUS; i++)
    begin : g_recip
        localparam logic [63:0] AREA = 64'((2 * i + 1) * (2 * i + 1));
        localparam logic [63:0] MV   = ((64'd1 << S) + AREA - 64'd1) / AREA;
        assign recip_tab[i] = MV[S-1:0];
    end

    bbw_ram #(.WIDTH(RGB_W), .DEPTH(LINES * MAX_WIDTH)) u_line_store (
        .clk   (clk),
        .we    (calc_en),
        .waddr (cur_addr_reg),
        .wdata (pix_reg),
        .raddr (q_old_addr),
        .rdata (ls_rdata)
    );

    bbw_ram #(.WIDTH(3 * CSW), .DEPTH(MAX_WIDTH)) u_col_sums (
        .clk   (clk),
        .we    (calc_en),
        .waddr (col_reg),
        .wdata (cs_wdata),
        .raddr (q_col),
        .rdata (cs_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_CALC;
                end
            end
            B_CALC:
            begin
                state_next = B_DIV;
            end
            B_DIV:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (!ctrl_reg.emit || !out_valid_reg || !out_stall)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop      = 1'b0;
        calc_en  = 1'b0;
        div_en   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                pop = !q_empty;
            end
            B_CALC:
            begin
                calc_en = 1'b1;
            end
            B_DIV:
            begin
                div_en = 1'b1;
            end
            B_EMIT:
            begin
                load_out = ctrl_reg.emit && (!out_valid_reg || !out_stall);
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign status.busy = (state_reg != B_IDLE);
    assign status.pop  = pop;
    assign drop_idx    = {r_eff, 1'b0};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (ctrl_reg.first_row)
            begin
                col_sum[c] = CSW'(pix_reg[PIX_W*c +: PIX_W]);
            end
            else
            begin
                col_sum[c] = cs_rdata[CSW*c +: CSW] + CSW'(pix_reg[PIX_W*c +: PIX_W])
                             - (ctrl_reg.sub_old ? CSW'(ls_rdata[PIX_W*c +: PIX_W])
                                                 : CSW'(0));
            end
            cs_wdata[CSW*c +: CSW] = col_sum[c];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            win_next[0][c] = col_sum[c];
            for (int k = 1; k < LINES; k++)
            begin
                win_next[k][c] = ctrl_reg.col_start ? CSW'(0) : win_reg[k-1][c];
            end
            if (ctrl_reg.col_start)
            begin
                sum_next[c] = SW'(col_sum[c]);
            end
            else
            begin
                sum_next[c] = sum_reg[c] + SW'(col_sum[c]) - SW'(win_reg[drop_idx][c]);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
                for (int k = 0; k < LINES; k++)
                begin
                    win_reg[k][c] <= '0;
                end
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (calc_en)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sum_reg[c] <= sum_next[c];
                    for (int k = 0; k < LINES; k++)
                    begin
                        win_reg[k][c] <= win_next[k][c];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ctrl_reg     <= q_ctrl;
            pix_reg      <= q_pixel;
            cur_addr_reg <= q_cur_addr;
            col_reg      <= q_col;
        end
        if (div_en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= PW'(sum_reg[c]) * PW'(recip_tab[r_eff]);
            end
        end
        if (load_out)
        begin
            center_row_reg <= ctrl_reg.center_row;
            center_col_reg <= ctrl_reg.center_col;
            for (int c = 0; c < 3; c++)
            begin
                mean_reg[c] <= prod_reg[c][S +: PIX_W];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign center_row  = center_row_reg;
    assign center_col  = center_col_reg;
    assign mean_first  = mean_reg[0];
    assign mean_second = mean_reg[1];
    assign mean_third  = mean_reg[2];

endmodule

/* bench/box_blur_rgb_window_test.sv */
// ----------------------------------------------------------------------------
// box_blur_rgb_window_test
// self-checking bench for the streaming rgb box blur block
// ----------------------------------------------------------------------------
// Frames of random pixels are streamed in raster order under several radius
// and frame size settings, directed extremes and degenerate settings first.
// An in-bench model of the running column and window sums predicts each
// window mean and centre, and every result request is compared in order.
// ----------------------------------------------------------------------------
module box_blur_rgb_window_test;
    import bbw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES = 15;
    localparam int WMAX  = 1024;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   m1;
        logic [PIX_W-1:0]   m2;
        logic [PIX_W-1:0]   m3;
    } blur_px_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [PIX_W-1:0]   first_byte = '0;
    logic [PIX_W-1:0]   second_byte = '0;
    logic [PIX_W-1:0]   third_byte = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
    logic [PIX_W-1:0]   mean_first;
    logic [PIX_W-1:0]   mean_second;
    logic [PIX_W-1:0]   mean_third;

    box_blur_rgb_window DUT (.*);

    always #6 clk = ~clk;

    // blur model state
    logic [7:0]  line_mem [LINES*WMAX][3];
    int unsigned col_acc [WMAX][3];
    int unsigned win_acc [LINES][3];
    int unsigned row_pos, col_pos;
    int unsigned cfg_r = 1, cfg_w = 1024, cfg_h = 1024;

    blur_px_t    blur_q [$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          blurs_seen = 0;
    int          frames_run = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    task automatic blur_predict(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2);
        logic [7:0]  p [3];
        int unsigned r, w, h, side, row, col, s, sum;
        blur_px_t    res;
        p[0] = b0; p[1] = b1; p[2] = b2;
        r = cfg_r > 7 ? 7 : cfg_r;
        w = cfg_w == 0 ? 1 : (cfg_w > WMAX ? WMAX : cfg_w);
        h = cfg_h == 0 ? 1 : (cfg_h > MAX_HEIGHT ? MAX_HEIGHT : cfg_h);
        side = 2 * r + 1;
        row = row_pos >= h ? 0 : row_pos;
        col = col_pos >= w ? 0 : col_pos;
        for (int c = 0; c < 3; c++)
        begin
            if (row == 0)
                s = 32'(p[c]);
            else
            begin
                s = col_acc[col][c] + 32'(p[c]);
                if (row >= side)
                    s -= 32'(line_mem[((row - side) % LINES) * WMAX + col][c]);
            end
            col_acc[col][c] = s;
            line_mem[(row % LINES) * WMAX + col][c] = p[c];
        end
        if (col == 0)
            foreach (win_acc[k, c]) win_acc[k][c] = 0;
        for (int k = LINES - 1; k > 0; k--)
            for (int c = 0; c < 3; c++)
                win_acc[k][c] = win_acc[k-1][c];
        for (int c = 0; c < 3; c++)
            win_acc[0][c] = col_acc[col][c];
        if (r >= 1 && r < w && r < h && row >= 2 * r && col >= 2 * r)
        begin
            res.row = COORD_W'(row - r);
            res.col = COORD_W'(col - r);
            for (int c = 0; c < 3; c++)
            begin
                sum = 0;
                for (int k = 0; k < side; k++)
                    sum += win_acc[k][c];
                sum = sum / (side * side);
                if (c == 0) res.m1 = sum[7:0];
                else if (c == 1) res.m2 = sum[7:0];
                else res.m3 = sum[7:0];
            end
            blur_q.push_back(res);
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        row_pos = row;
        col_pos = col;
    endtask

    task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        first_byte  <= b0;
        second_byte <= b1;
        third_byte  <= b2;
        do @(posedge clk); while (in_stall);
        blur_predict(b0, b1, b2);
        pixels_sent++;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RADIUS: cfg_r = 32'(val[2:0]);
            REG_WIDTH:  cfg_w = 32'(val[10:0]);
            REG_HEIGHT: cfg_h = 32'(val[10:0]);
            default: ;
        endcase
        if (idx != REG_NONE)
        begin
            row_pos = 0;
            col_pos = 0;
        end
    endtask

    task automatic set_frame(input int r, input int w, input int h);
        drain();
        write_reg(REG_RADIUS, r);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        frames_run++;
    endtask

    task automatic test_extremes();
        set_frame(1, 3, 3);
        repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
        repeat (9) send_pixel(8'h00, 8'h00, 8'h00);
        for (int i = 0; i < 9; i++)
            send_pixel(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, 8'hAA);
    endtask

    task automatic test_degenerate();
        send_random(10);
        set_frame(0, 4, 4);
        send_random(8);
        set_frame(3, 3, 8);
        send_random(10);
        set_frame(2, 0, 0);
        send_random(4);
        set_frame(1, 2047, 3);
        send_random(12);
        drain();
        write_reg(REG_NONE, 5);
        set_frame(7, 15, 16);
        send_random(240);
    endtask

    task automatic test_random_frames(input int budget);
        int r, w, h, frames, n;
        while (pixels_sent < budget)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                set_frame($urandom_range(0, 7), $urandom_range(0, 12),
                          $urandom_range(0, 12));
                send_random($urandom_range(1, 40));
            end
            else
            begin
                r = $urandom_range(0, 3) == 0 ? $urandom_range(3, 7)
                                              : $urandom_range(1, 2);
                w = $urandom_range(2 * r + 1, 2 * r + 10);
                h = $urandom_range(2 * r + 1, 2 * r + 8);
                frames = $urandom_range(1, 2);
                n = w * h * frames;
                if (n > budget - pixels_sent)
                    n = budget - pixels_sent;
                set_frame(r, w, h);
                send_random(n);
            end
        end
    endtask

    task automatic test_pause_until_empty();
        set_frame(2, 9, 7);
        send_random(35);
        in_valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge clk);
        send_random(28);
    endtask

    task automatic test_steady_stream();
        set_frame(1, 12, 8);
        calm = 1'b1;
        send_random(96);
        drain();
    endtask

    // result stall generator
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        blur_px_t exp_px;
        if (rst_n && out_valid && !out_stall)
        begin
            blurs_seen++;
            if (blur_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result row %0d col %0d", center_row, center_col);
            end
            else
            begin
                exp_px = blur_q.pop_front();
                if (exp_px != {center_row, center_col, mean_first, mean_second,
                               mean_third})
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp r%0d c%0d %0d/%0d/%0d got r%0d c%0d %0d/%0d/%0d",
                                 exp_px.row, exp_px.col, exp_px.m1, exp_px.m2, exp_px.m3,
                                 center_row, center_col, mean_first, mean_second,
                                 mean_third);
                end
            end
        end
    end

    initial
    begin
        row_pos = 0;
        col_pos = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_degenerate();
        test_extremes();
        test_pause_until_empty();
        test_random_frames(1350);
        test_steady_stream();
        if (blur_q.size() != 0)
            errors += blur_q.size();
        $display("%0d pixels over %0d frame settings, %0d blurred results checked",
                 pixels_sent, frames_run, blurs_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
